@@ rtl/strmm_pkg.sv @@
// ----------------------------------------------------------------------------
// strmm_pkg
// Shared types and fixed field widths of the sparse table range min/max core.
// ----------------------------------------------------------------------------
package strmm_pkg;

  localparam int OP_BITS      = 2;
  localparam int DATA_BITS    = 32;
  localparam int INDEX_BITS   = 10;
  localparam int STATUS_BITS  = 2;
  localparam int S_TDATA_BITS = 56;   // value, left, right packed, padded to bytes
  localparam int LEN_BITS     = INDEX_BITS + 1;
  localparam int LG_BITS      = 4;    // holds floor(log2) of a LEN_BITS length

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_QCHECK,
    S_QREAD2,
    S_QCOMBINE,
    S_FINISH
  } state_t;

endpackage

@@ rtl/sparse_table_range_minmax_core.sv @@
// ----------------------------------------------------------------------------
// sparse_table_range_minmax_core
// Range minimum / maximum query engine over a sparse table in one memory.
// ----------------------------------------------------------------------------
// The core takes one item at a time and returns exactly one result per item.
// Append stores a signed value at the next index and then walks up the
// levels: level k gets the entry of 2^k elements that ends at the new index,
// the combination of one stored entry of level k-1 and the entry just
// written one level below, which is held in a register and never re-read.
// The table lives in a single memory with one write and one registered read
// port, so an append writes level 0 when it is taken and then one level per
// step above it, up to level floor(log2(new count)) and at most the top level.
// A query checks its range, picks level floor(log2(length)) (saturated at the
// top level) and reads the two overlapping windows one after the other through
// the read port; an inverted or unloaded range skips both reads.
// Clear, refused appends and the unused op code go straight to finish. The finish
// step holds for as long as the consumer leaves the previous result waiting in
// the result register; a new item is taken while a finished result waits there.
// select_max picks minimum (0) or maximum (1); write it only while the core is
// idle. Entries keep the combination in force when they were written. Table
// contents are not cleared by reset or by a clear item; a query only reads
// entries written since the last clear. An inverted or unloaded range returns
// status 1 and answer zero, an append to a full table returns status 2.
module sparse_table_range_minmax_core #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input item stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [strmm_pkg::S_TDATA_BITS-1:0]    s_tdata,   // value[31:0], left_index[41:32],
                                                           // right_index[51:42], zero pad
  input  logic [strmm_pkg::OP_BITS-1:0]         s_tuser,   // op[1:0]
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [strmm_pkg::DATA_BITS-1:0]       m_tdata,   // answer[31:0]
  output logic [strmm_pkg::STATUS_BITS-1:0]     m_tuser,   // status[1:0]
  // configuration write: select_max
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data
);
  import strmm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int AW     = LVL_W + IDX_W;
  localparam int DEPTH  = LEVELS * (2 ** IDX_W);
  localparam int CMP_W  = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;
  localparam int XW     = (IDX_W > LEN_BITS) ? IDX_W : LEN_BITS;
  localparam int LGC_W  = (LVL_W > LG_BITS) ? LVL_W : LG_BITS;
  localparam int IN_VB  = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;

  // Signed min or max of two entries.
  function automatic logic [VALUE_BITS-1:0] combine(input logic [VALUE_BITS-1:0] a,
                                                    input logic [VALUE_BITS-1:0] b,
                                                    input logic                  use_max);
    logic a_less;
    a_less = $signed(a) < $signed(b);
    if (use_max) return a_less ? b : a;
    return a_less ? a : b;
  endfunction

  // Low bits of a stored value, zero-extended to the answer field.
  function automatic logic [DATA_BITS-1:0] to_answer(input logic [VALUE_BITS-1:0] v);
    return DATA_BITS'(v[IN_VB-1:0]);
  endfunction

  // Input field unpacking.
  logic [DATA_BITS-1:0]  in_value;
  logic [INDEX_BITS-1:0] in_left;
  logic [INDEX_BITS-1:0] in_right;
  op_t                   in_op;
  logic                  in_fire;

  assign in_value = s_tdata[DATA_BITS-1:0];
  assign in_left  = s_tdata[DATA_BITS +: INDEX_BITS];
  assign in_right = s_tdata[DATA_BITS+INDEX_BITS +: INDEX_BITS];
  assign in_op    = op_t'(s_tuser);
  assign in_fire  = s_tvalid && s_tready;

  // Control and data registers.
  state_t                  state, state_next;
  logic [CNT_W-1:0]        count;        // loaded elements
  logic                    sel_max;
  logic [CNT_W-1:0]        cnt1;         // new index + 1 during an append
  logic [CNT_W-1:0]        span;         // 2^lvl during an append
  logic [LVL_W-1:0]        lvl;          // level being filled / queried
  logic [IDX_W-1:0]        idx;          // start index of the entry being filled
  logic [VALUE_BITS-1:0]   cur;          // last written entry / first window
  logic [INDEX_BITS-1:0]   q_left;
  logic [INDEX_BITS-1:0]   q_right;
  logic [IDX_W-1:0]        q_bidx;       // start of the second window
  logic [DATA_BITS-1:0]    res_answer;
  status_t                 res_status;
  logic [DATA_BITS-1:0]    out_answer;
  status_t                 out_status;

  // Table memory.
  logic [VALUE_BITS-1:0]   mem [DEPTH];
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_BITS-1:0]   wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_BITS-1:0]   rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Append helpers.
  logic [VALUE_BITS-1:0]   in_ext;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        cnt_dec;
  logic [CNT_W:0]          span2;
  logic [CNT_W:0]          nstart;
  logic                    app_more;
  logic [VALUE_BITS-1:0]   app_new;

  // sign-extend from the stored width; a store wider than the input field
  // takes the field as unsigned
  assign in_ext   = (VALUE_BITS > DATA_BITS) ? VALUE_BITS'(in_value)
                                             : VALUE_BITS'($signed(in_value[IN_VB-1:0]));
  assign cnt_inc  = count + CNT_W'(1);
  assign cnt_dec  = count - CNT_W'(1);
  assign span2    = {span, 1'b0};
  assign nstart   = {1'b0, cnt1} - span2;
  assign app_more = (lvl < LVL_W'(LEVELS - 1)) && (span2 <= {1'b0, cnt1});
  assign app_new  = combine(rdata, cur, sel_max);

  // Query helpers: range check, level, window starts.
  logic                    q_bad;
  logic [LEN_BITS-1:0]     q_len;
  logic [LG_BITS-1:0]      lg_raw;
  logic [LVL_W-1:0]        lg_sat;
  logic [XW-1:0]           q_pow;
  logic [XW-1:0]           q_aext;
  logic [XW-1:0]           q_bext;

  always_comb begin
    q_bad  = (q_left > q_right) || (CMP_W'(q_right) >= CMP_W'(count));
    q_len  = LEN_BITS'(q_right) - LEN_BITS'(q_left) + LEN_BITS'(1);
    lg_raw = '0;
    for (int i = 0; i < LEN_BITS; i++) begin
      if (q_len[i]) lg_raw = LG_BITS'(i);
    end
    if (LGC_W'(lg_raw) > LGC_W'(LEVELS - 1)) begin
      lg_sat = LVL_W'(LEVELS - 1);
    end else begin
      lg_sat = LVL_W'(lg_raw);
    end
    q_pow  = XW'(1) << lg_sat;
    q_aext = XW'(q_left);
    q_bext = XW'(q_right) + XW'(1) - q_pow;
  end

  // Next state and memory control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    wr_addr    = {lvl, idx};
    wr_data    = app_new;
    rd_en      = 1'b0;
    rd_addr    = {lvl, nstart[IDX_W-1:0]};
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_APPEND: begin
              if (count == CNT_W'(MAX_ELEMENTS)) begin
                state_next = S_FINISH;
              end else begin
                mem_we  = 1'b1;
                wr_addr = {LVL_W'(0), count[IDX_W-1:0]};
                wr_data = in_ext;
                // level 1 needs the level-0 entry just before the new one
                rd_en   = (count != '0);
                rd_addr = {LVL_W'(0), cnt_dec[IDX_W-1:0]};
                state_next = (count != '0) ? S_APPEND : S_FINISH;
              end
            end
            OP_QUERY: state_next = S_QCHECK;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_APPEND: begin
        mem_we = 1'b1;
        rd_en  = app_more;
        state_next = app_more ? S_APPEND : S_FINISH;
      end
      S_QCHECK: begin
        rd_en   = !q_bad;
        rd_addr = {lg_sat, q_aext[IDX_W-1:0]};
        state_next = q_bad ? S_FINISH : S_QREAD2;
      end
      S_QREAD2: begin
        rd_en   = 1'b1;
        rd_addr = {lvl, q_bidx};
        state_next = S_QCOMBINE;
      end
      S_QCOMBINE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Element count and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sel_max <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) sel_max <= cfg_data;
      if (in_fire) begin
        if (in_op == OP_CLEAR) begin
          count <= '0;
        end else if (in_op == OP_APPEND && count != CNT_W'(MAX_ELEMENTS)) begin
          count <= cnt_inc;
        end
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_answer <= '0;
        res_status <= STAT_OK;
        q_left     <= in_left;
        q_right    <= in_right;
        cur        <= in_ext;
        cnt1       <= cnt_inc;
        span       <= CNT_W'(2);
        lvl        <= LVL_W'(1);
        idx        <= cnt_dec[IDX_W-1:0];
        if (in_op == OP_APPEND && count == CNT_W'(MAX_ELEMENTS)) begin
          res_status <= STAT_FULL;
        end
      end
      S_APPEND: begin
        // advance one level, keep the entry just written for the next combine
        cur  <= app_new;
        lvl  <= lvl + LVL_W'(1);
        idx  <= nstart[IDX_W-1:0];
        span <= span2[CNT_W-1:0];
      end
      S_QCHECK: begin
        lvl    <= lg_sat;
        q_bidx <= q_bext[IDX_W-1:0];
        if (q_bad) res_status <= STAT_RANGE;
      end
      S_QREAD2: begin
        cur <= rdata;
      end
      S_QCOMBINE: begin
        res_answer <= to_answer(combine(cur, rdata, sel_max));
      end
      default: begin
      end
    endcase
  end

  // Result register: hold until the consumer takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      out_answer <= res_answer;
      out_status <= res_status;
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_answer;
  assign m_tuser   = out_status;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above table size");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_APPEND))
    else $error("table write outside append");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of one entry in the same cycle");

  a_append_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> (lvl != '0 && int'(lvl) < LEVELS))
    else $error("append level out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result presented without a finished item");
`endif

endmodule

@@ tb/sparse_table_checker.sv @@
// ----------------------------------------------------------------------------
// sparse_table_checker
// Watches the item, result and select channels of the range min/max core,
// keeps its own sparse table and compares every result with its prediction.
// ----------------------------------------------------------------------------
module sparse_table_checker #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [strmm_pkg::S_TDATA_BITS-1:0]  s_tdata,
  input  logic [strmm_pkg::OP_BITS-1:0]       s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [strmm_pkg::DATA_BITS-1:0]     m_tdata,
  input  logic [strmm_pkg::STATUS_BITS-1:0]   m_tuser,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic                                cfg_data,
  output int                                  error_count,
  output int                                  outstanding
);
  import strmm_pkg::*;

  typedef struct packed {
    logic [DATA_BITS-1:0] answer;
    status_t              status;
  } result_t;

  logic signed [DATA_BITS-1:0] minmax_table [LEVELS][MAX_ELEMENTS];
  int unsigned                 loaded;
  bit                          pick_max;
  result_t                     results_due [$];
  result_t                     oldest;

  function automatic logic signed [DATA_BITS-1:0] pick(input logic signed [DATA_BITS-1:0] a,
                                                       input logic signed [DATA_BITS-1:0] b);
    if (pick_max) return (a < b) ? b : a;
    return (a < b) ? a : b;
  endfunction

  // Apply one item to the table copy and return the result it must produce.
  function automatic result_t run_table_op(input op_t code,
                                           input logic [DATA_BITS-1:0] value,
                                           input logic [INDEX_BITS-1:0] left,
                                           input logic [INDEX_BITS-1:0] right);
    result_t     res;
    int unsigned idx;
    int unsigned span;
    int unsigned start;
    int unsigned len;
    int unsigned lg;
    res.answer = '0;
    res.status = STAT_OK;
    case (code)
      OP_APPEND: begin
        if (loaded >= MAX_ELEMENTS) begin
          res.status = STAT_FULL;
        end else begin
          idx = loaded;
          minmax_table[0][idx] = value;
          for (int k = 1; k < LEVELS && (1 << k) <= idx + 1; k++) begin
            span  = 1 << k;
            start = idx + 1 - span;
            minmax_table[k][start] = pick(minmax_table[k-1][start],
                                          minmax_table[k-1][start + span/2]);
          end
          loaded = idx + 1;
        end
      end
      OP_QUERY: begin
        if (left > right || right >= loaded) begin
          res.status = STAT_RANGE;
        end else begin
          len = right - left + 1;
          lg  = 0;
          while (lg < LEVELS - 1 && (2 << lg) <= len) lg++;
          res.answer = pick(minmax_table[lg][left], minmax_table[lg][right + 1 - (1 << lg)]);
        end
      end
      OP_CLEAR: loaded = 0;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      results_due.delete();
      loaded   = 0;
      pick_max = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) pick_max = cfg_data;
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing due: answer %h status %0d",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          oldest = results_due.pop_front();
          if (m_tdata !== oldest.answer) begin
            $display("%0t: answer mismatch: expected %h actual %h",
                     $time, oldest.answer, m_tdata);
            error_count++;
          end
          if (m_tuser !== oldest.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, oldest.status, m_tuser);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        results_due = {results_due, run_table_op(op_t'(s_tuser), s_tdata[31:0],
                                                 s_tdata[41:32], s_tdata[51:42])};
    end
    outstanding = results_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sparse table range min/max core: directed
// corner items and a deeper table fill under both settings, random item mixes under maximum.
// ----------------------------------------------------------------------------
module tb_top;
  import strmm_pkg::*;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DEEP_FILL    = 64;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata   = '0;   // value[31:0], left_index[41:32],
                                             // right_index[51:42], zero pad
  logic [OP_BITS-1:0]      s_tuser   = OP_NONE;  // op[1:0]
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [DATA_BITS-1:0]    m_tdata;          // answer[31:0]
  logic [STATUS_BITS-1:0]  m_tuser;          // status[1:0]
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_data  = 1'b0;

  int error_count;
  int outstanding;
  int cycle_count  = 0;
  int stall_left   = 0;
  int loaded_count = 0;   // elements the core holds after every item sent so far
  bit idle_on      = 1'b0;

  always #4 clk = ~clk;

  sparse_table_range_minmax_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS),
    .VALUE_BITS  (DATA_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  sparse_table_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: now and then hold tready low for a random stall while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one item and hold it until the transfer; an optional gap goes first.
  // Called right after a rising edge, so tvalid gets one assignment per step.
  task automatic send(input op_t code, input logic [31:0] value,
                      input logic [INDEX_BITS-1:0] left, input logic [INDEX_BITS-1:0] right);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {4'b0000, right, left, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (code == OP_APPEND && loaded_count < MAX_ELEMENTS) loaded_count++;
    if (code == OP_CLEAR) loaded_count = 0;
  endtask

  // Drop tvalid and wait until every transfer has come back.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_select(input bit use_max);
    cfg_valid <= 1'b1;
    cfg_data  <= use_max;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly full-width random values, with ties and the signed extremes mixed in.
  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0:       return 32'($signed($urandom_range(0, 16)) - 8);
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_query(input bit legal);
    int right;
    int left;
    if (legal && loaded_count != 0) begin
      right = $urandom_range(0, loaded_count - 1);
      left  = $urandom_range(0, right);
    end else if ($urandom_range(0, 1) == 0 || loaded_count >= MAX_ELEMENTS) begin
      // inverted range
      right = $urandom_range(0, 1022);
      left  = $urandom_range(right + 1, 1023);
    end else begin
      // range reaching past the loaded elements
      right = $urandom_range(loaded_count, 1023);
      left  = $urandom_range(0, right);
    end
    send(OP_QUERY, $urandom(), left[INDEX_BITS-1:0], right[INDEX_BITS-1:0]);
  endtask

  // Random mix, weighted so tables grow about eleven deep on average between clears.
  // Idling is redrawn every 40 items; with quiet_tail the last 80 run without it.
  task automatic random_items(input int count, input bit quiet_tail);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (quiet_tail && i >= count - 80) idle_on = 1'b0;
      else if (i % 40 == 0)              idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send(OP_APPEND, any_value(), INDEX_BITS'($urandom()), INDEX_BITS'($urandom()));
      else if (pick < 80) send_query(1'b1);
      else if (pick < 92) send_query(1'b0);
      else if (pick < 96)
        send(OP_CLEAR, $urandom(), INDEX_BITS'($urandom()), INDEX_BITS'($urandom()));
      else
        send(OP_NONE, $urandom(), INDEX_BITS'($urandom()), INDEX_BITS'($urandom()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under minimum.
    write_select(1'b0);
    send(OP_QUERY,  32'h0,         10'd0,    10'd0);     // empty table
    send(OP_APPEND, 32'h7FFF_FFFF, 10'd0,    10'd0);
    send(OP_APPEND, 32'h8000_0000, 10'h3FF,  10'h3FF);
    send(OP_APPEND, 32'h0,         10'd0,    10'd0);
    send(OP_APPEND, 32'hFFFF_FFFF, 10'h3FF,  10'h3FF);
    send(OP_APPEND, 32'd5,         10'd0,    10'd0);
    send(OP_APPEND, 32'hFFFF_FFF9, 10'd0,    10'd0);
    send(OP_QUERY,  32'hFFFF_FFFF, 10'd0,    10'd5);
    send(OP_QUERY,  32'h0,         10'd1,    10'd1);
    send(OP_QUERY,  32'h0,         10'd2,    10'd5);
    send(OP_QUERY,  32'h0,         10'd0,    10'd1);
    send(OP_QUERY,  32'h0,         10'd3,    10'd1);     // inverted
    send(OP_QUERY,  32'h0,         10'd0,    10'd6);     // past the loaded end
    send(OP_QUERY,  32'h0,         10'h3FF,  10'h3FF);
    send(OP_NONE,   $urandom(),    INDEX_BITS'($urandom()), INDEX_BITS'($urandom()));
    send(OP_CLEAR,  32'h0,         10'd0,    10'd0);
    send(OP_QUERY,  32'h0,         10'd0,    10'd0);     // cleared table
    send(OP_APPEND, 32'd42,        10'd0,    10'd0);
    send(OP_APPEND, 32'd9,         10'd0,    10'd0);
    send(OP_APPEND, 32'hFFFF_FFFD, 10'd0,    10'd0);
    send(OP_APPEND, 32'd100,       10'd0,    10'd0);
    drain();

    // Switch to maximum over entries built under minimum, then build on them.
    write_select(1'b1);
    send(OP_QUERY,  32'h0,  10'd0, 10'd3);
    send(OP_QUERY,  32'h0,  10'd1, 10'd2);
    send(OP_APPEND, 32'd8,  10'd0, 10'd0);
    send(OP_QUERY,  32'h0,  10'd1, 10'd4);
    random_items(120, 1'b0);
    drain();

    // Grow a deeper table from empty and query wide, narrow, inverted and random ranges.
    write_select(1'b0);
    idle_on = 1'b1;
    send(OP_CLEAR, 32'h0, 10'd0, 10'd0);
    for (int i = 0; i < DEEP_FILL; i++)
      send(OP_APPEND, any_value(), INDEX_BITS'($urandom()), INDEX_BITS'($urandom()));
    send(OP_QUERY, 32'h0, 10'd0,  10'd63);
    send(OP_QUERY, 32'h0, 10'd63, 10'd63);
    send(OP_QUERY, 32'h0, 10'd1,  10'd63);
    send(OP_QUERY, 32'h0, 10'd31, 10'd32);
    send(OP_QUERY, 32'h0, 10'd63, 10'd0);
    repeat (20) send_query(1'b1);
    drain();

    // Maximum over the same table, then a fresh random mix ending without idling.
    write_select(1'b1);
    repeat (10) send_query(1'b1);
    send(OP_CLEAR, 32'h0, 10'd0, 10'd0);
    random_items(160, 1'b1);
    drain();

    repeat (20) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/strmm_pkg.sv
rtl/sparse_table_range_minmax_core.sv
tb/sparse_table_checker.sv
tb/tb_top.sv
